// ===== rtl/lgcs_pkg.sv =====
// lgcs_pkg: shared types, constants and elaboration-time tables for the
// lattice gas collision selector. No dependencies.
package lgcs_pkg;

  // field widths
  localparam int unsigned CellW   = 9;
  localparam int unsigned MoveW   = 8;
  localparam int unsigned FracW   = 17;
  localparam int unsigned NumMove = 1 << MoveW;
  localparam int unsigned CntW    = 8;
  localparam int unsigned KW      = 9;
  localparam int unsigned ProdW   = FracW + KW;

  // fraction of one in Q1.16 and the rounding half
  localparam logic [FracW-1:0] FRAC_ONE  = FracW'(65536);
  localparam logic [ProdW-1:0] FRAC_HALF = ProdW'(32768);

  // momentum key layout: pop * 49 + (mx + 3) * 7 + (my + 3)
  localparam int MomOfs  = 3;
  localparam int MomSpan = 2 * MomOfs + 1;
  localparam int PopStep = MomSpan * MomSpan;

  // per-state lookup: the group of the state and the groups one particle
  // below and above it with the same momentum
  typedef struct packed {
    logic [MoveW-1:0] own_base;
    logic [CntW-1:0]  own_cnt;
    logic [MoveW-1:0] dn_base;
    logic [CntW-1:0]  dn_cnt;
    logic [MoveW-1:0] up_base;
    logic [CntW-1:0]  up_cnt;
  } grp_info_t;

  typedef grp_info_t [NumMove-1:0]        grp_tbl_t;
  typedef logic [NumMove-1:0][MoveW-1:0]  member_tbl_t;

  function automatic int dir_dx(int b);
    int d;
    case (b)
      0, 1, 7: d = -1;
      3, 4, 5: d = 1;
      default: d = 0;
    endcase
    return d;
  endfunction

  function automatic int dir_dy(int b);
    int d;
    case (b)
      1, 2, 3: d = 1;
      5, 6, 7: d = -1;
      default: d = 0;
    endcase
    return d;
  endfunction

  // group key of an 8-bit moving-particle pattern
  function automatic int key_of(int t);
    int p;
    int mx;
    int my;
    p  = 0;
    mx = 0;
    my = 0;
    for (int b = 0; b < MoveW; b++) begin
      if (((t >> b) & 1) == 1) begin
        p  = p + 1;
        mx = mx + dir_dx(b);
        my = my + dir_dy(b);
      end
    end
    return p * PopStep + (mx + MomOfs) * MomSpan + (my + MomOfs);
  endfunction

  // group start offsets and sizes, groups sorted by key
  function automatic grp_tbl_t build_grp_tbl();
    int       keys [NumMove];
    grp_tbl_t tbl;
    int       k;
    int       b_own, c_own, b_dn, c_dn, b_up, c_up;
    for (int t = 0; t < NumMove; t++) keys[t] = key_of(t);
    for (int t = 0; t < NumMove; t++) begin
      k = keys[t];
      b_own = 0; c_own = 0; b_dn = 0; c_dn = 0; b_up = 0; c_up = 0;
      for (int u = 0; u < NumMove; u++) begin
        if (keys[u] < k) b_own++;
        if (keys[u] == k) c_own++;
        if (keys[u] < k - PopStep) b_dn++;
        if (keys[u] == k - PopStep) c_dn++;
        if (keys[u] < k + PopStep) b_up++;
        if (keys[u] == k + PopStep) c_up++;
      end
      tbl[t].own_base = MoveW'(b_own);
      tbl[t].own_cnt  = CntW'(c_own);
      tbl[t].dn_base  = MoveW'(b_dn);
      tbl[t].dn_cnt   = CntW'(c_dn);
      tbl[t].up_base  = MoveW'(b_up);
      tbl[t].up_cnt   = CntW'(c_up);
    end
    return tbl;
  endfunction

  // all patterns grouped by key, ascending within each group
  function automatic member_tbl_t build_member_tbl();
    int          keys [NumMove];
    member_tbl_t tbl;
    int          pos;
    for (int t = 0; t < NumMove; t++) keys[t] = key_of(t);
    for (int t = 0; t < NumMove; t++) begin
      pos = 0;
      for (int u = 0; u < NumMove; u++) begin
        if (keys[u] < keys[t]) pos++;
        if (keys[u] == keys[t] && u < t) pos++;
      end
      tbl[pos] = MoveW'(t);
    end
    return tbl;
  endfunction

  localparam grp_tbl_t    GRP_TBL    = build_grp_tbl();
  localparam member_tbl_t MEMBER_TBL = build_member_tbl();

endpackage

// ===== rtl/lattice_gas_collision_select_core.sv =====
// lattice_gas_collision_select_core: D2Q8 lattice gas collision selector.
// Depends on lgcs_pkg (group and member tables).

// The block takes one cell word per cycle while out_ready_i is high and returns
// one new occupancy word per cell, in order. It is a five-stage pipeline: mirror
// and fraction clamp, group lookup, rank scaling (one 17 x 9 multiply), rank
// split between the no-rest and rest groups, and member lookup into the output
// register. Each stage holds its word while the next one is full and stalled,
// and empty stages let new words in even while a result waits at the output.
module lattice_gas_collision_select_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lgcs_pkg::CellW-1:0]  cell_state_i,
  input  logic [lgcs_pkg::FracW-1:0]  random_fraction_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lgcs_pkg::CellW-1:0]  new_state_o
);
  import lgcs_pkg::*;

  localparam int unsigned NumStg = 5;

  // stage valids and load enables
  logic [NumStg:1]   v_q, v_d;
  logic [NumStg+1:1] en;

  // stage 1: mirrored pattern, rest bit, clamped fraction
  logic [MoveW-1:0] s1_mir_q, s1_mir_d;
  logic             s1_rest_q, s1_rest_d;
  logic [FracW-1:0] s1_frac_q, s1_frac_d;

  // stage 2: the two candidate groups
  logic [MoveW-1:0] s2_base_a_q, s2_base_a_d, s2_base_b_q, s2_base_b_d;
  logic [CntW-1:0]  s2_cnt_a_q, s2_cnt_a_d, s2_cnt_b_q, s2_cnt_b_d;
  logic [FracW-1:0] s2_frac_q;
  grp_info_t        info;

  // stage 3: scaled rank
  logic [KW-1:0]    s3_k_q, s3_k_d;
  logic [MoveW-1:0] s3_base_a_q, s3_base_b_q;
  logic [CntW-1:0]  s3_cnt_a_q, s3_cnt_b_q;
  logic [KW-1:0]    count, count_m1;
  logic [ProdW-1:0] prod;

  // stage 4: member index
  logic [MoveW-1:0] s4_idx_q, s4_idx_d;
  logic             s4_rest_q, s4_rest_d;

  // stage 5: output word
  logic [CellW-1:0] s5_new_state_q, s5_new_state_d;

  // load enables: a stage loads when empty or when it drains downstream
  always_comb begin
    en[NumStg+1] = out_ready_i;
    for (int i = NumStg; i >= 1; i--) en[i] = ~v_q[i] | en[i+1];
  end

  assign in_ready_o = en[1];

  always_comb begin
    v_d = v_q;
    if (en[1]) v_d[1] = in_valid_i;
    for (int i = 2; i <= NumStg; i++) begin
      if (en[i]) v_d[i] = v_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // stage 1: a half-turn rotation negates the momentum; clamp r to one
  always_comb begin
    s1_mir_d  = {cell_state_i[3:0], cell_state_i[7:4]};
    s1_rest_d = cell_state_i[MoveW];
    s1_frac_d = random_fraction_i[FracW-1] ? FRAC_ONE : random_fraction_i;
  end

  // stage 2: groups without and with the rest particle
  always_comb begin
    info = GRP_TBL[s1_mir_q];
    if (s1_rest_q) begin
      s2_base_a_d = info.up_base;
      s2_cnt_a_d  = info.up_cnt;
      s2_base_b_d = info.own_base;
      s2_cnt_b_d  = info.own_cnt;
    end else begin
      s2_base_a_d = info.own_base;
      s2_cnt_a_d  = info.own_cnt;
      s2_base_b_d = info.dn_base;
      s2_cnt_b_d  = info.dn_cnt;
    end
  end

  // stage 3: k = round(r * (count - 1))
  always_comb begin
    count    = KW'(s2_cnt_a_q) + KW'(s2_cnt_b_q);
    count_m1 = count - KW'(1);
    prod     = ProdW'(s2_frac_q) * ProdW'(count_m1) + FRAC_HALF;
    s3_k_d   = prod[16 +: KW];
  end

  // stage 4: candidates below 256 come first, then those with the rest bit
  always_comb begin
    if (s3_k_q < KW'(s3_cnt_a_q)) begin
      s4_idx_d  = s3_base_a_q + s3_k_q[MoveW-1:0];
      s4_rest_d = 1'b0;
    end else begin
      s4_idx_d  = s3_base_b_q + MoveW'(s3_k_q - KW'(s3_cnt_a_q));
      s4_rest_d = 1'b1;
    end
  end

  // stage 5: member lookup
  assign s5_new_state_d = {s4_rest_q, MEMBER_TBL[s4_idx_q]};

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_mir_q  <= s1_mir_d;
      s1_rest_q <= s1_rest_d;
      s1_frac_q <= s1_frac_d;
    end
    if (en[2]) begin
      s2_base_a_q <= s2_base_a_d;
      s2_cnt_a_q  <= s2_cnt_a_d;
      s2_base_b_q <= s2_base_b_d;
      s2_cnt_b_q  <= s2_cnt_b_d;
      s2_frac_q   <= s1_frac_q;
    end
    if (en[3]) begin
      s3_k_q      <= s3_k_d;
      s3_base_a_q <= s2_base_a_q;
      s3_cnt_a_q  <= s2_cnt_a_q;
      s3_base_b_q <= s2_base_b_q;
      s3_cnt_b_q  <= s2_cnt_b_q;
    end
    if (en[4]) begin
      s4_idx_q  <= s4_idx_d;
      s4_rest_q <= s4_rest_d;
    end
    if (en[5]) begin
      s5_new_state_q <= s5_new_state_d;
    end
  end

  assign out_valid_o = v_q[NumStg];
  assign new_state_o = s5_new_state_q;

`ifndef SYNTHESIS
  // an accepted word lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[1])
    else $error("accepted word not in first stage");

  // back-pressure only when every stage is occupied
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q))
    else $error("input stalled with an empty stage");

  // scaled rank stays inside the candidate list
  a_rank_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> (s3_k_q < (KW'(s3_cnt_a_q) + KW'(s3_cnt_b_q))))
    else $error("rank beyond candidate count");
`endif

endmodule

// ===== dv/lgcs_collision_checker.sv =====
// lgcs_collision_checker: watches the cell and result channels of the collision
// selector, predicts each new occupancy word and compares it in order.
// Depends on lgcs_pkg for the field widths and the fraction of one.
module lgcs_collision_checker
  import lgcs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [CellW-1:0] cell_state_i,
  input  logic [FracW-1:0] random_fraction_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [CellW-1:0] new_state_i,
  output int               err_cnt_o,
  output int               pend_cnt_o,
  output int               done_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumCells  = 1 << CellW;
  localparam int PrintCap  = 40;
  localparam int RoundHalf = 32768;

  logic [CellW-1:0] expected_states_q [$];
  logic [CellW-1:0] want_state;
  int               err_cnt  = 0;
  int               done_cnt = 0;
  int               pend_cnt = 0;

  assign err_cnt_o  = err_cnt;
  assign pend_cnt_o = pend_cnt;
  assign done_cnt_o = done_cnt;

  // particles in the cell, rest particle included
  function automatic int particle_count(logic [CellW-1:0] s);
    int n;
    n = 0;
    for (int b = 0; b < CellW; b++) n += int'(s[b]);
    return n;
  endfunction

  // x momentum: directions 3,4,5 move right, 0,1,7 move left
  function automatic int drift_x(logic [CellW-1:0] s);
    return int'(s[3]) + int'(s[4]) + int'(s[5]) - int'(s[0]) - int'(s[1]) - int'(s[7]);
  endfunction

  // y momentum: directions 1,2,3 move up, 5,6,7 move down
  function automatic int drift_y(logic [CellW-1:0] s);
    return int'(s[1]) + int'(s[2]) + int'(s[3]) - int'(s[5]) - int'(s[6]) - int'(s[7]);
  endfunction

  // pick the scaled-rank member among states with equal count and reversed momentum
  function automatic logic [CellW-1:0] collide_pick(logic [CellW-1:0] cell_word,
                                                    logic [FracW-1:0] frac);
    int               pop;
    int               tx;
    int               ty;
    int               n;
    int               rank;
    int               seen;
    longint           v;
    logic [CellW-1:0] s;
    logic [CellW-1:0] pick;
    pop  = particle_count(cell_word);
    tx   = -drift_x(cell_word);
    ty   = -drift_y(cell_word);
    n    = 0;
    seen = 0;
    pick = '0;
    for (int i = 0; i < NumCells; i++) begin
      s = CellW'(i);
      if (particle_count(s) == pop && drift_x(s) == tx && drift_y(s) == ty) n++;
    end
    if (n == 0) return '0;
    // fractions above one saturate to one
    v = (frac > FRAC_ONE) ? longint'(FRAC_ONE) : longint'(frac);
    rank = int'((v * longint'(n - 1) + longint'(RoundHalf)) >>> 16);
    if (rank > n - 1) rank = n - 1;
    for (int i = 0; i < NumCells; i++) begin
      s = CellW'(i);
      if (particle_count(s) == pop && drift_x(s) == tx && drift_y(s) == ty) begin
        if (seen == rank) begin
          pick = s;
          break;
        end
        seen++;
      end
    end
    return pick;
  endfunction

  task automatic report_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= PrintCap) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // compare finished words, then queue the prediction for a newly accepted cell
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_states_q.delete();
      pend_cnt = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_states_q.size() == 0) begin
          report_mismatch($sformatf("new_state %03h with no cell outstanding", new_state_i));
        end else begin
          want_state = expected_states_q.pop_front();
          if (new_state_i !== want_state)
            report_mismatch($sformatf("new_state %03h, predicted %03h",
                                      new_state_i, want_state));
          done_cnt++;
        end
      end
      if (in_valid_i && in_ready_i)
        expected_states_q.push_back(collide_pick(cell_state_i, random_fraction_i));
      pend_cnt = expected_states_q.size();
    end
  end

endmodule

// ===== dv/tb_lattice_gas_collision_select_core.sv =====
// tb_lattice_gas_collision_select_core: drives cell words into the collision
// selector under four flow-control phases and reports the verdict.
// Depends on lgcs_pkg, the core and lgcs_collision_checker.
module tb_lattice_gas_collision_select_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lgcs_pkg::*;

  localparam int ResetCycles   = 8;
  localparam int QuietLimit    = 4000;
  localparam int DrainCycles   = 12;
  localparam int WordsPerPhase = 500;
  localparam int NumPhases     = 4;

  logic             clk_i             = 1'b0;
  logic             rst_ni            = 1'b0;
  logic             in_valid_i        = 1'b0;
  logic             in_ready_o;
  logic [CellW-1:0] cell_state_i      = '0;
  logic [FracW-1:0] random_fraction_i = '0;
  logic             out_valid_o;
  logic             out_ready_i       = 1'b0;
  logic [CellW-1:0] new_state_o;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int cells_sent     = 0;
  int quiet_cycles   = 0;
  int err_cnt;
  int pend_cnt;
  int done_cnt;

  always #5 clk_i = ~clk_i;

  lattice_gas_collision_select_core DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cell_state_i      (cell_state_i),
    .random_fraction_i (random_fraction_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .new_state_o       (new_state_o)
  );

  lgcs_collision_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .cell_state_i      (cell_state_i),
    .random_fraction_i (random_fraction_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .new_state_i       (new_state_o),
    .err_cnt_o         (err_cnt),
    .pend_cnt_o        (pend_cnt),
    .done_cnt_o        (done_cnt)
  );

  // result side back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // hang detection: cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("no word moved for %0d cycles", quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // present one cell word, idling first at the phase's rate, and hold it until taken
  task automatic send_word(input logic [CellW-1:0] cell_word,
                           input logic [FracW-1:0] frac);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    cell_state_i      <= cell_word;
    random_fraction_i <= frac;
    do @(posedge clk_i); while (!in_ready_o);
    cells_sent++;
  endtask

  // fraction mix: both ends, the midpoint area, saturation and plain values
  function automatic logic [FracW-1:0] rand_fraction();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0:       return '0;
      1:       return FRAC_ONE;
      2:       return FracW'($urandom_range(131071, 65537));
      3:       return FracW'($urandom_range(32800, 32736));
      default: return FracW'($urandom_range(65536, 0));
    endcase
  endfunction

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words: empty, full, rest only, single movers, head-on pairs
    send_word(9'h000, 17'd0);
    send_word(9'h000, 17'd65536);
    send_word(9'h1ff, 17'd0);
    send_word(9'h1ff, 17'd65536);
    for (int b = 0; b < CellW; b++) send_word(CellW'(1 << b), FracW'(b * 8192));
    send_word(9'h011, 17'd32768);
    send_word(9'h044, 17'd32768);
    send_word(9'h0ff, 17'd65535);
    send_word(9'h0aa, 17'd131071);
    send_word(9'h155, 17'd65537);
    send_word(9'h10f, 17'd98304);
    send_word(9'h0f0, 17'd1);
    send_word(9'h033, 17'd16384);
    send_word(9'h1e1, 17'd49152);

    // random words under each flow-control phase
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 85; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 85; end
        default: begin src_idle_pct = 23; sink_stall_pct = 23; end
      endcase
      for (int i = 0; i < WordsPerPhase; i++)
        send_word(CellW'($urandom_range(511)), rand_fraction());
    end
    in_valid_i <= 1'b0;

    // drain outstanding results, then allow for the pipeline depth
    do @(negedge clk_i); while (pend_cnt != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d cell words sent, %0d new states checked across idle and stall phases,",
             cells_sent, done_cnt);
    $display("with empty, full, single-mover, head-on and saturated-fraction cases");
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", err_cnt, pend_cnt);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lgcs_pkg.sv
rtl/lattice_gas_collision_select_core.sv
dv/lgcs_collision_checker.sv
dv/tb_lattice_gas_collision_select_core.sv
